@@ design/awce_pkg.sv @@
// Shared types and constants for the analog window comparator event unit.
package awce_pkg;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int LVL_BITS      = 16;
  localparam int STEADY_BITS   = 32;
  localparam int CODE_BITS     = 4;
  localparam int COUNT_BITS    = 16;

  localparam logic [LVL_BITS-1:0]    HIGH_LEVEL_RST  = 16'd800;
  localparam logic [LVL_BITS-1:0]    LOW_LEVEL_RST   = 16'd200;
  localparam logic [LVL_BITS-1:0]    HYST_RST        = 16'd20;
  localparam logic [LVL_BITS-1:0]    DELTA_LIMIT_RST = 16'hFFFF;
  localparam logic [LVL_BITS-1:0]    STEP_SIZE_RST   = 16'hFFFF;
  localparam logic [STEADY_BITS-1:0] STEADY_RST      = 32'hFFFF_FFFF;

  // pending-event mask, emitted lowest bit first
  localparam int MB_STEP   = 0;
  localparam int MB_DELTA  = 1;
  localparam int MB_REGION = 2;
  localparam int MB_CHANGE = 3;
  localparam int MB_STEADY = 4;
  localparam int MB_EXC    = 5;
  localparam int MASK_BITS = 6;

  typedef enum logic [2:0] {
    RG_LOW   = 3'd0,
    RG_HIGH  = 3'd1,
    RG_BAND  = 3'd2,
    RG_SLOW  = 3'd3,
    RG_SHIGH = 3'd4,
    RG_SBAND = 3'd5,
    RG_NONE  = 3'd7
  } region_t;

  typedef enum logic [CODE_BITS-1:0] {
    EV_STEP_UP     = 4'd0,
    EV_STEP_DOWN   = 4'd1,
    EV_DELTA       = 4'd2,
    EV_HIGH        = 4'd3,
    EV_LOW         = 4'd4,
    EV_BAND        = 4'd5,
    EV_CHANGE      = 4'd6,
    EV_STEADY_HIGH = 4'd7,
    EV_STEADY_LOW  = 4'd8,
    EV_STEADY_BAND = 4'd9,
    EV_EXCEPTION   = 4'd10
  } ev_code_t;

  typedef enum logic [2:0] {
    REG_HIGH_LEVEL   = 3'd0,
    REG_LOW_LEVEL    = 3'd1,
    REG_HYST_WIDTH   = 3'd2,
    REG_DELTA_LIMIT  = 3'd3,
    REG_STEP_SIZE    = 3'd4,
    REG_STEADY_HIGH  = 3'd5,
    REG_STEADY_LOW   = 3'd6,
    REG_STEADY_BAND  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EVAL = 2'd2,
    ST_EMIT = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic [LVL_BITS-1:0]    high_level;
    logic [LVL_BITS-1:0]    low_level;
    logic [LVL_BITS-1:0]    hysteresis_width;
    logic [LVL_BITS-1:0]    delta_limit;
    logic [LVL_BITS-1:0]    step_size;
    logic [STEADY_BITS-1:0] steady_high_ticks;
    logic [STEADY_BITS-1:0] steady_low_ticks;
    logic [STEADY_BITS-1:0] steady_band_ticks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic pend;
    logic last;
  } ctrl_sts_t;

endpackage

@@ design/awce_if.sv @@
// Request channel interfaces for samples in and events out.
interface awce_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int TICK_BITS   = 32
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TICK_BITS-1:0]   now_tick;
  logic                   check_delta;

  modport source (output valid, sample, now_tick, check_delta, input ready);
  modport sink   (input valid, sample, now_tick, check_delta, output ready);
endinterface

interface awce_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [15:0] step_count;
  logic        last_event;

  modport source (output valid, event_code, step_count, last_event, input ready);
  modport sink   (input valid, event_code, step_count, last_event, output ready);
endinterface

@@ design/awce_regs.sv @@
// APB-style configuration register file.
module awce_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [awce_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [awce_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [awce_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output awce_pkg::cfg_t                      cfg
);

  awce_pkg::cfg_t     cfg_r;
  awce_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = awce_pkg::reg_idx_t'(paddr[awce_pkg::CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_level        <= awce_pkg::HIGH_LEVEL_RST;
      cfg_r.low_level         <= awce_pkg::LOW_LEVEL_RST;
      cfg_r.hysteresis_width  <= awce_pkg::HYST_RST;
      cfg_r.delta_limit       <= awce_pkg::DELTA_LIMIT_RST;
      cfg_r.step_size         <= awce_pkg::STEP_SIZE_RST;
      cfg_r.steady_high_ticks <= awce_pkg::STEADY_RST;
      cfg_r.steady_low_ticks  <= awce_pkg::STEADY_RST;
      cfg_r.steady_band_ticks <= awce_pkg::STEADY_RST;
    end else if (wr_en) begin
      unique case (idx)
        awce_pkg::REG_HIGH_LEVEL:  cfg_r.high_level        <= pwdata[15:0];
        awce_pkg::REG_LOW_LEVEL:   cfg_r.low_level         <= pwdata[15:0];
        awce_pkg::REG_HYST_WIDTH:  cfg_r.hysteresis_width  <= pwdata[15:0];
        awce_pkg::REG_DELTA_LIMIT: cfg_r.delta_limit       <= pwdata[15:0];
        awce_pkg::REG_STEP_SIZE:   cfg_r.step_size         <= pwdata[15:0];
        awce_pkg::REG_STEADY_HIGH: cfg_r.steady_high_ticks <= pwdata;
        awce_pkg::REG_STEADY_LOW:  cfg_r.steady_low_ticks  <= pwdata;
        awce_pkg::REG_STEADY_BAND: cfg_r.steady_band_ticks <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      awce_pkg::REG_HIGH_LEVEL:  prdata = 32'(cfg_r.high_level);
      awce_pkg::REG_LOW_LEVEL:   prdata = 32'(cfg_r.low_level);
      awce_pkg::REG_HYST_WIDTH:  prdata = 32'(cfg_r.hysteresis_width);
      awce_pkg::REG_DELTA_LIMIT: prdata = 32'(cfg_r.delta_limit);
      awce_pkg::REG_STEP_SIZE:   prdata = 32'(cfg_r.step_size);
      awce_pkg::REG_STEADY_HIGH: prdata = cfg_r.steady_high_ticks;
      awce_pkg::REG_STEADY_LOW:  prdata = cfg_r.steady_low_ticks;
      awce_pkg::REG_STEADY_BAND: prdata = cfg_r.steady_band_ticks;
    endcase
  end

endmodule

@@ design/awce_div.sv @@
// Restoring divider, one quotient bit per cycle.
module awce_div #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [SAMPLE_BITS-1:0]            dividend,
  input  logic [awce_pkg::LVL_BITS-1:0]     divisor,
  output logic [SAMPLE_BITS-1:0]            quotient,
  output logic                              busy
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);
  localparam int DW       = awce_pkg::LVL_BITS;

  logic [SAMPLE_BITS-1:0] q_r;
  logic [DW-1:0]          rem_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic                   busy_r;
  logic [DW:0]            shifted;
  logic [DW+1:0]          trial;

  assign shifted  = {rem_r, q_r[SAMPLE_BITS-1]};
  // extra top bit keeps a zero divisor from looking negative: quotient all ones
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign quotient = q_r;
  assign busy     = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(SAMPLE_BITS);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_r <= trial[DW-1:0];
        q_r   <= {q_r[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DW-1:0];
        q_r   <= {q_r[SAMPLE_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/awce_dp.sv @@
// Datapath: sample latch, step divider, region state and event queue.
module awce_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  awce_pkg::ctrl_cmd_t                 cmd,
  input  awce_pkg::cfg_t                      cfg,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic [TICK_BITS-1:0]                now_tick,
  input  logic                                check_delta,
  output awce_pkg::ctrl_sts_t                 sts,
  output logic [awce_pkg::CODE_BITS-1:0]      event_code,
  output logic [awce_pkg::COUNT_BITS-1:0]     step_count,
  output logic                                last_event
);

  localparam int CW = (SAMPLE_BITS > awce_pkg::LVL_BITS) ? SAMPLE_BITS : awce_pkg::LVL_BITS;
  localparam int W  = CW + 1;
  localparam int TW = (TICK_BITS > awce_pkg::STEADY_BITS) ? TICK_BITS : awce_pkg::STEADY_BITS;
  localparam int MB = awce_pkg::MASK_BITS;

  logic [SAMPLE_BITS-1:0] v_r;
  logic [TICK_BITS-1:0]   now_r;
  logic                   act_r;

  awce_pkg::region_t      region_r, region_nxt;
  logic [SAMPLE_BITS-1:0] lsi_r, lsi_nxt;
  logic [SAMPLE_BITS-1:0] ref_r, ref_nxt;
  logic [TICK_BITS-1:0]   ct_r, ct_nxt;
  logic [MB-1:0]          mask_r, mask_nxt;
  awce_pkg::ev_code_t     dir_r, dir_nxt;
  awce_pkg::ev_code_t     evr_r, evr_nxt;
  awce_pkg::ev_code_t     evs_r, evs_nxt;
  logic [awce_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [SAMPLE_BITS-1:0] quo;
  logic                   div_busy;

  logic [W-1:0]           v_w, hi_w, lo_w, hy_w;
  logic                   cfg_bad;
  logic                   up;
  logic [SAMPLE_BITS-1:0] sdiff, ddiff;
  logic                   step_sat;
  logic                   dlt_hit;
  logic [TICK_BITS-1:0]   elapsed;
  logic                   trans;
  awce_pkg::region_t      tgt;
  logic [awce_pkg::STEADY_BITS-1:0] limit;
  awce_pkg::ev_code_t     evs_sel;
  logic                   steady_hit;
  logic [MB-1:0]          cur_oh;

  awce_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (sample),
    .divisor  (cfg.step_size),
    .quotient (quo),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r   <= sample;
      now_r <= now_tick;
      act_r <= check_delta;
    end
  end

  assign v_w  = W'(v_r);
  assign hi_w = W'(cfg.high_level);
  assign lo_w = W'(cfg.low_level);
  assign hy_w = W'(cfg.hysteresis_width);

  assign cfg_bad = (cfg.high_level < cfg.low_level) ||
                   ((cfg.high_level - cfg.low_level) <= cfg.hysteresis_width) ||
                   (cfg.step_size == '0);

  assign up       = quo > lsi_r;
  assign sdiff    = up ? (quo - lsi_r) : (lsi_r - quo);
  assign step_sat = CW'(sdiff) > CW'(16'hFFFF);
  assign ddiff    = (v_r > ref_r) ? (v_r - ref_r) : (ref_r - v_r);
  assign dlt_hit  = CW'(ddiff) >= CW'(cfg.delta_limit);
  assign elapsed  = now_r - ct_r;

  // threshold crossings with hysteresis on band re-entry
  always_comb begin
    trans   = 1'b0;
    tgt     = awce_pkg::RG_BAND;
    limit   = cfg.steady_band_ticks;
    evs_sel = awce_pkg::EV_STEADY_BAND;
    unique case (region_r)
      awce_pkg::RG_LOW, awce_pkg::RG_SLOW: begin
        limit   = cfg.steady_low_ticks;
        evs_sel = awce_pkg::EV_STEADY_LOW;
        if (v_w > hi_w) begin
          trans = 1'b1;
          tgt   = awce_pkg::RG_HIGH;
        end else if (v_w > lo_w + hy_w) begin
          trans = 1'b1;
        end
      end
      awce_pkg::RG_HIGH, awce_pkg::RG_SHIGH: begin
        limit   = cfg.steady_high_ticks;
        evs_sel = awce_pkg::EV_STEADY_HIGH;
        if (v_w < lo_w) begin
          trans = 1'b1;
          tgt   = awce_pkg::RG_LOW;
        end else if (v_w + hy_w < hi_w) begin
          trans = 1'b1;
        end
      end
      default: begin
        if (v_w > hi_w) begin
          trans = 1'b1;
          tgt   = awce_pkg::RG_HIGH;
        end else if (v_w < lo_w) begin
          trans = 1'b1;
          tgt   = awce_pkg::RG_LOW;
        end
      end
    endcase
  end

  assign steady_hit = ((region_r == awce_pkg::RG_LOW) || (region_r == awce_pkg::RG_HIGH) ||
                       (region_r == awce_pkg::RG_BAND)) && (TW'(elapsed) > TW'(limit));

  always_comb begin
    region_nxt = region_r;
    lsi_nxt    = lsi_r;
    ref_nxt    = ref_r;
    ct_nxt     = ct_r;
    mask_nxt   = '0;
    dir_nxt    = awce_pkg::EV_STEP_UP;
    cnt_nxt    = '0;
    evr_nxt    = awce_pkg::EV_BAND;
    evs_nxt    = evs_sel;
    if (region_r == awce_pkg::RG_NONE) begin
      // first sample only seeds the state
      if (v_w > hi_w) region_nxt = awce_pkg::RG_HIGH;
      else if (v_w < lo_w) region_nxt = awce_pkg::RG_LOW;
      else region_nxt = awce_pkg::RG_BAND;
      lsi_nxt = quo;
      ref_nxt = v_r;
      ct_nxt  = now_r;
    end else if (cfg_bad) begin
      mask_nxt[awce_pkg::MB_EXC] = 1'b1;
    end else begin
      if (quo != lsi_r) begin
        mask_nxt[awce_pkg::MB_STEP] = 1'b1;
        dir_nxt = up ? awce_pkg::EV_STEP_UP : awce_pkg::EV_STEP_DOWN;
        cnt_nxt = step_sat ? '1 : awce_pkg::COUNT_BITS'(sdiff);
        lsi_nxt = quo;
      end
      if (act_r) begin
        mask_nxt[awce_pkg::MB_DELTA] = dlt_hit;
        ref_nxt = v_r;
      end
      if (trans) begin
        mask_nxt[awce_pkg::MB_REGION] = 1'b1;
        mask_nxt[awce_pkg::MB_CHANGE] = 1'b1;
        evr_nxt = (tgt == awce_pkg::RG_HIGH) ? awce_pkg::EV_HIGH :
                  (tgt == awce_pkg::RG_LOW)  ? awce_pkg::EV_LOW  : awce_pkg::EV_BAND;
        region_nxt = tgt;
        ct_nxt     = now_r;
      end else if (steady_hit) begin
        mask_nxt[awce_pkg::MB_STEADY] = 1'b1;
        region_nxt = (region_r == awce_pkg::RG_LOW)  ? awce_pkg::RG_SLOW :
                     (region_r == awce_pkg::RG_HIGH) ? awce_pkg::RG_SHIGH : awce_pkg::RG_SBAND;
        ct_nxt     = now_r;
      end
    end
  end

  // lowest pending bit goes out first
  assign cur_oh = mask_r & (~mask_r + MB'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= awce_pkg::RG_NONE;
      lsi_r    <= '0;
      ref_r    <= '0;
      ct_r     <= '0;
      mask_r   <= '0;
    end else if (cmd.eval) begin
      region_r <= region_nxt;
      lsi_r    <= lsi_nxt;
      ref_r    <= ref_nxt;
      ct_r     <= ct_nxt;
      mask_r   <= mask_nxt;
    end else if (cmd.pop) begin
      mask_r   <= mask_r & ~cur_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dir_r <= dir_nxt;
      cnt_r <= cnt_nxt;
      evr_r <= evr_nxt;
      evs_r <= evs_nxt;
    end
  end

  always_comb begin
    event_code = awce_pkg::EV_EXCEPTION;
    step_count = '0;
    priority if (mask_r[awce_pkg::MB_STEP]) begin
      event_code = dir_r;
      step_count = cnt_r;
    end else if (mask_r[awce_pkg::MB_DELTA]) begin
      event_code = awce_pkg::EV_DELTA;
    end else if (mask_r[awce_pkg::MB_REGION]) begin
      event_code = evr_r;
    end else if (mask_r[awce_pkg::MB_CHANGE]) begin
      event_code = awce_pkg::EV_CHANGE;
    end else if (mask_r[awce_pkg::MB_STEADY]) begin
      event_code = evs_r;
    end else begin
      event_code = awce_pkg::EV_EXCEPTION;
    end
  end

  assign last_event   = ((mask_r & ~cur_oh) == '0);
  assign sts.div_busy = div_busy;
  assign sts.pend     = (mask_r != '0);
  assign sts.last     = last_event;

`ifndef SYNTHESIS
  a_exc_alone: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r[awce_pkg::MB_EXC] |-> (mask_r == MB'(1 << awce_pkg::MB_EXC)))
    else $error("exception queued with other events");
  a_region_then_change: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r[awce_pkg::MB_REGION] |-> mask_r[awce_pkg::MB_CHANGE])
    else $error("region event without on-change event");
  a_no_steady_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    !(mask_r[awce_pkg::MB_STEADY] && mask_r[awce_pkg::MB_CHANGE]))
    else $error("steady event queued with a transition");
  a_seeded_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |=> (region_r != awce_pkg::RG_NONE))
    else $error("region left unset after evaluation");
  a_no_eval_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> !div_busy)
    else $error("evaluation before quotient ready");
`endif

endmodule

@@ design/awce_ctrl.sv @@
// Controller: sequences load, divide, evaluate and event emission.
module awce_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  awce_pkg::ctrl_sts_t  sts,
  output awce_pkg::ctrl_cmd_t  cmd
);

  awce_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= awce_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      awce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = awce_pkg::ST_DIV;
        end
      end
      awce_pkg::ST_DIV: begin
        if (!sts.div_busy) state_nxt = awce_pkg::ST_EVAL;
      end
      awce_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = awce_pkg::ST_EMIT;
      end
      awce_pkg::ST_EMIT: begin
        if (!sts.pend) begin
          state_nxt = awce_pkg::ST_IDLE;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.pop = 1'b1;
            if (sts.last) state_nxt = awce_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

@@ design/analog_window_comparator_events_unit.sv @@
// Top level of the analog window comparator event unit.
// After a sample request is accepted, the unit loads it, runs the step divider, evaluates
// and then offers its events; it takes one sample at a time, with no new request taken
// until the last event is out. The bit-serial step divider gives one quotient bit a cycle.
// Reset (rst_n, synchronous, active low) restores register defaults and arms the next
// sample as the seeding sample that gives no events.
module analog_window_comparator_events_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  awce_in_if.sink                             in_ch,
  awce_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [awce_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [awce_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [awce_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  awce_pkg::cfg_t      cfg;
  awce_pkg::ctrl_cmd_t cmd;
  awce_pkg::ctrl_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  awce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  awce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  awce_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TICK_BITS   (TICK_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .sample      (in_ch.sample),
    .now_tick    (in_ch.now_tick),
    .check_delta (in_ch.check_delta),
    .sts         (sts),
    .event_code  (out_ch.event_code),
    .step_count  (out_ch.step_count),
    .last_event  (out_ch.last_event)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Window comparator event unit test: an event predictor checks every event request from the DUT.
module tb_top;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 24;

  typedef struct packed {
    awce_pkg::ev_code_t              code;
    logic [awce_pkg::COUNT_BITS-1:0] count;
    logic                            last;
  } event_rec_t;

  class event_tracker;
    awce_pkg::cfg_t                cfg;
    awce_pkg::region_t             region;
    logic [awce_pkg::LVL_BITS-1:0] step_idx;
    logic [awce_pkg::LVL_BITS-1:0] ref_sample;
    logic [31:0]                   change_tick;
    event_rec_t                    pending_events[$];
    int                            errors;

    function new();
      cfg = '{high_level: awce_pkg::HIGH_LEVEL_RST, low_level: awce_pkg::LOW_LEVEL_RST,
              hysteresis_width: awce_pkg::HYST_RST,
              delta_limit: awce_pkg::DELTA_LIMIT_RST,
              step_size: awce_pkg::STEP_SIZE_RST,
              steady_high_ticks: awce_pkg::STEADY_RST,
              steady_low_ticks: awce_pkg::STEADY_RST,
              steady_band_ticks: awce_pkg::STEADY_RST};
      region = awce_pkg::RG_NONE;
      step_idx = '0;
      ref_sample = '0;
      change_tick = '0;
      errors = 0;
    endfunction

    function void set_reg(awce_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        awce_pkg::REG_HIGH_LEVEL:  cfg.high_level = val[15:0];
        awce_pkg::REG_LOW_LEVEL:   cfg.low_level = val[15:0];
        awce_pkg::REG_HYST_WIDTH:  cfg.hysteresis_width = val[15:0];
        awce_pkg::REG_DELTA_LIMIT: cfg.delta_limit = val[15:0];
        awce_pkg::REG_STEP_SIZE:   cfg.step_size = val[15:0];
        awce_pkg::REG_STEADY_HIGH: cfg.steady_high_ticks = val;
        awce_pkg::REG_STEADY_LOW:  cfg.steady_low_ticks = val;
        default:                   cfg.steady_band_ticks = val;
      endcase
    endfunction

    function void add_event(awce_pkg::ev_code_t code, logic [15:0] count);
      event_rec_t rec;
      rec.code = code;
      rec.count = count;
      rec.last = 1'b0;
      pending_events.push_back(rec);
    endfunction

    function void note_sample(logic [15:0] smp, logic [31:0] tick, logic chk);
      int                 base;
      logic [15:0]        cur;
      logic [15:0]        delta_mag;
      logic [16:0]        lo_margin;
      logic [16:0]        hi_margin;
      logic [31:0]        limit;
      awce_pkg::region_t  nxt;
      awce_pkg::ev_code_t steady_ev;
      event_rec_t         tail;
      base = pending_events.size();
      // seeding sample: sets state only
      if (region == awce_pkg::RG_NONE) begin
        if (smp > cfg.high_level) region = awce_pkg::RG_HIGH;
        else if (smp < cfg.low_level) region = awce_pkg::RG_LOW;
        else region = awce_pkg::RG_BAND;
        step_idx = (cfg.step_size != 0) ? smp / cfg.step_size : '1;
        ref_sample = smp;
        change_tick = tick;
        return;
      end
      if (cfg.high_level < cfg.low_level ||
          cfg.high_level - cfg.low_level <= cfg.hysteresis_width ||
          cfg.step_size == 0) begin
        add_event(awce_pkg::EV_EXCEPTION, '0);
      end else begin
        // 16-bit operands, so the step count never exceeds the saturation value
        cur = smp / cfg.step_size;
        if (cur > step_idx) add_event(awce_pkg::EV_STEP_UP, cur - step_idx);
        else if (cur < step_idx) add_event(awce_pkg::EV_STEP_DOWN, step_idx - cur);
        step_idx = cur;
        if (chk) begin
          delta_mag = (smp > ref_sample) ? smp - ref_sample : ref_sample - smp;
          if (delta_mag >= cfg.delta_limit) add_event(awce_pkg::EV_DELTA, '0);
          ref_sample = smp;
        end
        lo_margin = {1'b0, cfg.low_level} + cfg.hysteresis_width;
        hi_margin = {1'b0, smp} + cfg.hysteresis_width;
        nxt = awce_pkg::RG_NONE;
        case (region)
          awce_pkg::RG_LOW, awce_pkg::RG_SLOW: begin
            if (smp > cfg.high_level) nxt = awce_pkg::RG_HIGH;
            else if ({1'b0, smp} > lo_margin) nxt = awce_pkg::RG_BAND;
            limit = cfg.steady_low_ticks;
            steady_ev = awce_pkg::EV_STEADY_LOW;
          end
          awce_pkg::RG_HIGH, awce_pkg::RG_SHIGH: begin
            if (smp < cfg.low_level) nxt = awce_pkg::RG_LOW;
            else if (hi_margin < {1'b0, cfg.high_level}) nxt = awce_pkg::RG_BAND;
            limit = cfg.steady_high_ticks;
            steady_ev = awce_pkg::EV_STEADY_HIGH;
          end
          default: begin
            if (smp > cfg.high_level) nxt = awce_pkg::RG_HIGH;
            else if (smp < cfg.low_level) nxt = awce_pkg::RG_LOW;
            limit = cfg.steady_band_ticks;
            steady_ev = awce_pkg::EV_STEADY_BAND;
          end
        endcase
        if (nxt != awce_pkg::RG_NONE) begin
          if (nxt == awce_pkg::RG_HIGH) add_event(awce_pkg::EV_HIGH, '0);
          else if (nxt == awce_pkg::RG_LOW) add_event(awce_pkg::EV_LOW, '0);
          else add_event(awce_pkg::EV_BAND, '0);
          add_event(awce_pkg::EV_CHANGE, '0);
          region = nxt;
          change_tick = tick;
        end else if ((region == awce_pkg::RG_LOW || region == awce_pkg::RG_HIGH ||
                      region == awce_pkg::RG_BAND) &&
                     tick - change_tick > limit) begin
          // steady regions have no timer of their own
          add_event(steady_ev, '0);
          case (region)
            awce_pkg::RG_LOW:  region = awce_pkg::RG_SLOW;
            awce_pkg::RG_HIGH: region = awce_pkg::RG_SHIGH;
            default:           region = awce_pkg::RG_SBAND;
          endcase
          change_tick = tick;
        end
      end
      if (pending_events.size() > base) begin
        tail = pending_events.pop_back();
        tail.last = 1'b1;
        pending_events.push_back(tail);
      end
    endfunction

    function void check_event(logic [3:0] code, logic [15:0] count, logic last);
      event_rec_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: expected no event, got code %0d count %0d last %0b",
                 $time, code, count, last);
        return;
      end
      want = pending_events.pop_front();
      if (code !== want.code) begin
        errors++;
        $display("%0t: event_code expected %0d got %0d", $time, want.code, code);
      end
      if (count !== want.count) begin
        errors++;
        $display("%0t: step_count expected %0d got %0d", $time, want.count, count);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_event expected %0b got %0b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [awce_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [awce_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [awce_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                               pready;
  bit                                 gaps_off = 1'b0;
  int                                 quiet_cycles = 0;
  event_tracker                       tracker = new();

  awce_in_if #(.SAMPLE_BITS(16), .TICK_BITS(32)) in_ch();
  awce_out_if out_ch();

  analog_window_comparator_events_unit #(
    .SAMPLE_BITS(16),
    .TICK_BITS  (32)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return gaps_off ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [15:0] sample_near(int center, int spread);
    int v;
    v = center - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic write_reg(awce_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_cfg(awce_pkg::cfg_t c);
    write_reg(awce_pkg::REG_HIGH_LEVEL, 32'(c.high_level));
    write_reg(awce_pkg::REG_LOW_LEVEL, 32'(c.low_level));
    write_reg(awce_pkg::REG_HYST_WIDTH, 32'(c.hysteresis_width));
    write_reg(awce_pkg::REG_DELTA_LIMIT, 32'(c.delta_limit));
    write_reg(awce_pkg::REG_STEP_SIZE, 32'(c.step_size));
    write_reg(awce_pkg::REG_STEADY_HIGH, c.steady_high_ticks);
    write_reg(awce_pkg::REG_STEADY_LOW, c.steady_low_ticks);
    write_reg(awce_pkg::REG_STEADY_BAND, c.steady_band_ticks);
  endtask

  // valid stays high across back-to-back requests; it drops only for a gap or in drain_events
  task automatic send_sample(logic [15:0] smp, logic [31:0] tick, logic chk);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.now_tick <= tick;
    in_ch.check_delta <= chk;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every predicted event is out, then let a silent sample finish
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_sample(in_ch.sample, in_ch.now_tick, in_ch.check_delta);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_event(out_ch.event_code, out_ch.step_count, out_ch.last_event);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : ready_driver
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    awce_pkg::cfg_t cfg_now;
    int             lo;
    int             hy;
    int             hi;
    logic [31:0]    tick;
    logic [15:0]    smp;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.now_tick <= '0;
    in_ch.check_delta <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero step at seed time: index becomes all ones, next request is an exception
    write_reg(awce_pkg::REG_STEP_SIZE, 32'd0);
    send_sample(16'd1000, 32'd0, 1'b0);
    send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    drain_events();

    // widest band, unit step, zero delta limit, steady times of one tick
    cfg_now = '{high_level: 16'hFFFF, low_level: 16'd0, hysteresis_width: 16'd0,
                delta_limit: 16'd0, step_size: 16'd1, steady_high_ticks: 32'd1,
                steady_low_ticks: 32'd1, steady_band_ticks: 32'd1};
    program_cfg(cfg_now);
    send_sample(16'd0, 32'd10, 1'b1);
    send_sample(16'hFFFF, 32'd12, 1'b1);
    send_sample(16'hFFFF, 32'd20, 1'b0);
    drain_events();

    // walk through every region with hysteresis and steady timing
    cfg_now = '{high_level: 16'd800, low_level: 16'd200, hysteresis_width: 16'd20,
                delta_limit: 16'd100, step_size: 16'd100, steady_high_ticks: 32'd50,
                steady_low_ticks: 32'd50, steady_band_ticks: 32'd50};
    program_cfg(cfg_now);
    send_sample(16'd850, 32'd100, 1'b1);
    send_sample(16'd790, 32'd110, 1'b0);
    send_sample(16'd779, 32'd120, 1'b0);
    send_sample(16'd779, 32'd171, 1'b0);
    send_sample(16'd150, 32'd180, 1'b1);
    send_sample(16'd220, 32'd190, 1'b0);
    send_sample(16'd221, 32'd195, 1'b0);
    // transition with the timer also expired: no steady event
    send_sample(16'd100, 32'd300, 1'b1);
    send_sample(16'd100, 32'd400, 1'b0);
    send_sample(16'd900, 32'd401, 1'b0);
    send_sample(16'd900, 32'd452, 1'b1);
    send_sample(16'd900, 32'hFFFF_FFF0, 1'b0);
    drain_events();

    // thresholds crossed over
    cfg_now.high_level = 16'd100;
    cfg_now.low_level = 16'd200;
    program_cfg(cfg_now);
    send_sample(16'd150, 32'd5, 1'b1);
    send_sample(16'd0, 32'd6, 1'b0);
    drain_events();

    // band no wider than the hysteresis
    cfg_now = '{high_level: 16'd300, low_level: 16'd200, hysteresis_width: 16'hFFFF,
                delta_limit: 16'hFFFF, step_size: 16'hFFFF, steady_high_ticks: 32'hFFFF_FFFF,
                steady_low_ticks: 32'hFFFF_FFFF, steady_band_ticks: 32'hFFFF_FFFF};
    program_cfg(cfg_now);
    send_sample(16'd250, 32'd7, 1'b1);
    drain_events();

    tick = 32'd1000;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      lo = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 40000));
      hy = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 1500));
      hi = ($urandom_range(0, 7) == 0) ? 65535 : lo + hy + 1 + int'($urandom_range(0, 20000));
      cfg_now.high_level = 16'(hi);
      cfg_now.low_level = 16'(lo);
      cfg_now.hysteresis_width = 16'(hy);
      // occasional broken setup
      case ($urandom_range(0, 11))
        0: begin
          cfg_now.high_level = 16'(lo);
          cfg_now.low_level = 16'(hi);
        end
        1: cfg_now.hysteresis_width = 16'(hi - lo);
        default: ;
      endcase
      case ($urandom_range(0, 11))
        0: cfg_now.step_size = 16'd0;
        1: cfg_now.step_size = 16'd1;
        2: cfg_now.step_size = 16'hFFFF;
        default: cfg_now.step_size = 16'($urandom_range(2, 3000));
      endcase
      case ($urandom_range(0, 5))
        0: cfg_now.delta_limit = 16'hFFFF;
        1: cfg_now.delta_limit = 16'd0;
        default: cfg_now.delta_limit = 16'($urandom_range(1, 3000));
      endcase
      cfg_now.steady_high_ticks = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF :
                                  32'($urandom_range(1, 400));
      cfg_now.steady_low_ticks = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF :
                                 32'($urandom_range(1, 400));
      cfg_now.steady_band_ticks = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF :
                                  32'($urandom_range(1, 400));
      program_cfg(cfg_now);
      gaps_off = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0: tick = $urandom();
          1: ;
          default: tick = tick + $urandom_range(1, 150);
        endcase
        // mostly samples around the thresholds and their hysteresis margins
        case ($urandom_range(0, 5))
          0: smp = 16'($urandom_range(0, 65535));
          1: smp = sample_near(lo, hy + 16);
          2: smp = sample_near(lo + hy, hy + 16);
          3: smp = sample_near(hi, hy + 16);
          4: smp = sample_near(hi - hy, hy + 16);
          default: smp = sample_near((lo + hi) / 2, hy + 16);
        endcase
        send_sample(smp, tick, 1'($urandom_range(0, 1)));
      end
      drain_events();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/awce_pkg.sv
design/awce_if.sv
design/awce_regs.sv
design/awce_div.sv
design/awce_dp.sv
design/awce_ctrl.sv
design/analog_window_comparator_events_unit.sv
test/tb_top.sv
